FILE: hw/rtl/aflv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aflv_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 13;
    localparam int TS_W   = 32;
    localparam int IDX_W  = 4;

    localparam logic [DATA_W-1:0] FLV_TAG_AUDIO  = 8'h08;
    localparam logic [DATA_W-1:0] AAC_SOUND_BYTE = 8'hAF;
    localparam logic [DATA_W-1:0] AAC_PKT_SEQ    = 8'h00;
    localparam logic [DATA_W-1:0] AAC_PKT_RAW    = 8'h01;

    // length of the ADTS header; frames no longer than this are skipped
    localparam logic [LEN_W-1:0] ADTS_HDR_LEN   = 13'd7;
    // data size of a raw tag is frame_length - 7 + 2
    localparam logic [LEN_W-1:0] RAW_SIZE_ADJ   = 13'd5;
    localparam logic [LEN_W-1:0] SEQ_TAG_SIZE   = 13'd4;
    localparam logic [LEN_W-1:0] POS_MAX        = 13'h1FFF;

    // word positions inside a tag burst
    localparam logic [IDX_W-1:0] IDX_SOUND  = 4'd11;
    localparam logic [IDX_W-1:0] IDX_PKT    = 4'd12;
    localparam logic [IDX_W-1:0] IDX_ASC0   = 4'd13;
    localparam logic [IDX_W-1:0] IDX_ASC1   = 4'd14;

    typedef enum logic [1:0] {
        DK_HDR,
        DK_SEQ,
        DK_BYTE
    } t_desc_kind;

    // one queued burst of result words
    typedef struct packed {
        t_desc_kind              kind;
        logic [TS_W-1:0]         stamp;
        logic [LEN_W-1:0]        size;
        logic [DATA_W-1:0]       b0;
        logic [DATA_W-1:0]       b1;
        logic                    end_flag;
        logic                    trunc_flag;
    } t_desc;

endpackage

`default_nettype wire

FILE: hw/rtl/aflv_adts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aflv_adts_if;
    logic                         valid;
    logic                         ready;
    logic [aflv_pkg::DATA_W-1:0]  adts_data;
    logic [aflv_pkg::LEN_W-1:0]   frame_length;
    logic [aflv_pkg::TS_W-1:0]    time_stamp;
    logic                         frame_end;

    modport source (output valid, adts_data, frame_length, time_stamp, frame_end,
                    input ready);
    modport sink   (input valid, adts_data, frame_length, time_stamp, frame_end,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/aflv_tag_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aflv_tag_if;
    logic                         valid;
    logic                         ready;
    logic [aflv_pkg::DATA_W-1:0]  tag_data;
    logic                         tag_end;
    logic                         tag_kind;
    logic                         truncated;

    modport source (output valid, tag_data, tag_end, tag_kind, truncated,
                    input ready);
    modport sink   (input valid, tag_data, tag_end, tag_kind, truncated,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/adts_to_flv_audio_tagger.sv
// An accepted byte's burst descriptor is registered in the burst queue (A), then in the output
// sequencer (B). Throughput: payload bytes pass at one word per cycle while the output is ready;
// a frame's first byte (13 or 14 words) and the sequence-header byte (15 words) hold the output
// for their whole burst, and the one-entry burst queue (A) lets one more byte in meanwhile.
// Reset (i_rst_n low, synchronous): frame tracking goes idle, queue and output empty,
// and the sequence header is pending again.
`timescale 1ns / 1ps
`default_nettype none

module adts_to_flv_audio_tagger (
    input  wire         i_clk,
    input  wire         i_rst_n,
    aflv_adts_if.sink   i_adts,
    aflv_tag_if.source  o_tag
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_SEQ  = 2'd1;
    localparam logic [1:0] MODE_RAW  = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    logic                          r_seq_done;
    logic [aflv_pkg::LEN_W-1:0]    r_byte_position;
    logic [aflv_pkg::LEN_W-1:0]    r_held_length;
    logic [aflv_pkg::TS_W-1:0]     r_held_stamp;
    logic [aflv_pkg::DATA_W-1:0]   r_adts_third_byte;
    logic [1:0]                    r_frame_mode;

    logic                          n_seq_done;
    logic [aflv_pkg::LEN_W-1:0]    n_byte_position;
    logic [aflv_pkg::LEN_W-1:0]    n_held_length;
    logic [aflv_pkg::TS_W-1:0]     n_held_stamp;
    logic [aflv_pkg::DATA_W-1:0]   n_adts_third_byte;
    logic [1:0]                    n_frame_mode;

    aflv_pkg::t_desc               r_a;
    logic                          r_a_valid;
    aflv_pkg::t_desc               r_b;
    logic                          r_b_valid;
    logic [aflv_pkg::IDX_W-1:0]    r_idx;

    aflv_pkg::t_desc               n_desc;
    logic                          n_push;

    logic [aflv_pkg::LEN_W-1:0]    pos;
    logic [aflv_pkg::LEN_W-1:0]    len;
    logic [1:0]                    mode_eff;
    logic [2:0]                    profile;
    logic [3:0]                    sr_idx;
    logic [2:0]                    chan;
    logic                          last_byte;

    logic                          in_fire;
    logic                          out_fire;
    logic                          out_last;
    logic                          b_done;
    logic                          a_move;
    logic [aflv_pkg::IDX_W-1:0]    last_idx;

    assign out_fire     = o_tag.valid && o_tag.ready;
    assign b_done       = out_fire && out_last;
    assign a_move       = r_a_valid && (!r_b_valid || b_done);
    assign i_adts.ready = !r_a_valid || a_move;
    assign in_fire      = i_adts.valid && i_adts.ready;

    // per-byte frame tracking and burst descriptor
    always_comb begin
        n_seq_done        = r_seq_done;
        n_held_length     = r_held_length;
        n_held_stamp      = r_held_stamp;
        n_adts_third_byte = r_adts_third_byte;
        n_push            = 1'b0;
        n_desc            = '{kind: aflv_pkg::DK_BYTE, stamp: r_held_stamp,
                              size: aflv_pkg::SEQ_TAG_SIZE, b0: i_adts.adts_data,
                              b1: '0, end_flag: 1'b0, trunc_flag: 1'b0};
        profile           = {1'b0, r_adts_third_byte[7:6]} + 3'd1;
        sr_idx            = r_adts_third_byte[5:2];
        chan              = {r_adts_third_byte[0], i_adts.adts_data[7:6]};

        if (r_frame_mode == MODE_IDLE) begin
            pos           = '0;
            len           = i_adts.frame_length;
            n_held_length = i_adts.frame_length;
            n_held_stamp  = i_adts.time_stamp;
            if (i_adts.frame_length <= aflv_pkg::ADTS_HDR_LEN) begin
                mode_eff = MODE_SKIP;
            end else if (!r_seq_done) begin
                mode_eff = MODE_SEQ;
            end else begin
                mode_eff = MODE_RAW;
            end
        end else begin
            pos      = r_byte_position;
            len      = r_held_length;
            mode_eff = r_frame_mode;
        end

        last_byte = (pos == len - 13'd1);

        unique case (mode_eff)
            MODE_SEQ: begin
                if (pos == 13'd2) begin
                    n_adts_third_byte = i_adts.adts_data;
                end else if (pos == 13'd3) begin
                    n_push          = 1'b1;
                    n_desc.kind     = aflv_pkg::DK_SEQ;
                    n_desc.stamp    = r_held_stamp;
                    n_desc.size     = aflv_pkg::SEQ_TAG_SIZE;
                    n_desc.b0       = {2'b00, profile, sr_idx[3:1]};
                    n_desc.b1       = {sr_idx[0], 1'b0, chan, 3'b000};
                    n_desc.end_flag = 1'b1;
                    n_seq_done      = 1'b1;
                end
            end
            MODE_RAW: begin
                if (r_frame_mode == MODE_IDLE) begin
                    // frame start: tag header, trailing truncation word if it ends here
                    n_push            = 1'b1;
                    n_desc.kind       = aflv_pkg::DK_HDR;
                    n_desc.stamp      = i_adts.time_stamp;
                    n_desc.size       = i_adts.frame_length - aflv_pkg::RAW_SIZE_ADJ;
                    n_desc.trunc_flag = i_adts.frame_end;
                end else if (pos >= aflv_pkg::ADTS_HDR_LEN && pos < len) begin
                    n_push            = 1'b1;
                    n_desc.kind       = aflv_pkg::DK_BYTE;
                    n_desc.b0         = i_adts.adts_data;
                    n_desc.end_flag   = last_byte || i_adts.frame_end;
                    n_desc.trunc_flag = i_adts.frame_end && !last_byte;
                end else if (i_adts.frame_end && pos < aflv_pkg::ADTS_HDR_LEN) begin
                    n_push            = 1'b1;
                    n_desc.kind       = aflv_pkg::DK_BYTE;
                    n_desc.b0         = '0;
                    n_desc.end_flag   = 1'b1;
                    n_desc.trunc_flag = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (i_adts.frame_end) begin
            n_frame_mode    = MODE_IDLE;
            n_byte_position = '0;
        end else begin
            n_frame_mode    = mode_eff;
            n_byte_position = (pos == aflv_pkg::POS_MAX) ? pos : pos + 13'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_done        <= 1'b0;
            r_byte_position   <= '0;
            r_held_length     <= '0;
            r_held_stamp      <= '0;
            r_adts_third_byte <= '0;
            r_frame_mode      <= MODE_IDLE;
        end else if (in_fire) begin
            r_seq_done        <= n_seq_done;
            r_byte_position   <= n_byte_position;
            r_held_length     <= n_held_length;
            r_held_stamp      <= n_held_stamp;
            r_adts_third_byte <= n_adts_third_byte;
            r_frame_mode      <= n_frame_mode;
        end
    end

    // burst queue (A) and output sequencer (B)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (in_fire && n_push) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end

            if (a_move) begin
                r_b_valid <= 1'b1;
                r_idx     <= '0;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
                r_idx     <= '0;
            end else if (out_fire) begin
                r_idx     <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_push) begin
            r_a <= n_desc;
        end
        if (a_move) begin
            r_b <= r_a;
        end
    end

    always_comb begin
        unique case (r_b.kind)
            aflv_pkg::DK_HDR:  last_idx = r_b.trunc_flag ? aflv_pkg::IDX_ASC0 : aflv_pkg::IDX_PKT;
            aflv_pkg::DK_SEQ:  last_idx = aflv_pkg::IDX_ASC1;
            default:           last_idx = '0;
        endcase
    end

    assign out_last = (r_idx == last_idx);

    // word select for the current burst position
    always_comb begin
        o_tag.tag_end   = 1'b0;
        o_tag.truncated = 1'b0;
        o_tag.tag_kind  = (r_b.kind != aflv_pkg::DK_SEQ);
        o_tag.tag_data  = '0;
        if (r_b.kind == aflv_pkg::DK_BYTE) begin
            o_tag.tag_data  = r_b.b0;
            o_tag.tag_end   = r_b.end_flag;
            o_tag.truncated = r_b.trunc_flag;
        end else begin
            unique case (r_idx)
                4'd0:  o_tag.tag_data = aflv_pkg::FLV_TAG_AUDIO;
                4'd2:  o_tag.tag_data = {3'b000, r_b.size[12:8]};
                4'd3:  o_tag.tag_data = r_b.size[7:0];
                4'd4:  o_tag.tag_data = r_b.stamp[23:16];
                4'd5:  o_tag.tag_data = r_b.stamp[15:8];
                4'd6:  o_tag.tag_data = r_b.stamp[7:0];
                4'd7:  o_tag.tag_data = r_b.stamp[31:24];
                4'd11: o_tag.tag_data = aflv_pkg::AAC_SOUND_BYTE;
                4'd12: o_tag.tag_data = (r_b.kind == aflv_pkg::DK_SEQ) ?
                                        aflv_pkg::AAC_PKT_SEQ : aflv_pkg::AAC_PKT_RAW;
                4'd13: begin
                    if (r_b.kind == aflv_pkg::DK_SEQ) begin
                        o_tag.tag_data = r_b.b0;
                    end else begin
                        o_tag.tag_end   = 1'b1;
                        o_tag.truncated = 1'b1;
                    end
                end
                4'd14: begin
                    o_tag.tag_data = r_b.b1;
                    o_tag.tag_end  = 1'b1;
                end
                default: o_tag.tag_data = '0;
            endcase
        end
    end

    assign o_tag.valid = r_b_valid;

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_idx <= last_idx))
        else $error("burst index past last word");

    a_idx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !o_tag.ready) |=> $stable(r_idx))
        else $error("burst index moved while output stalled");

    a_seq_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_done |=> r_seq_done)
        else $error("sequence header flag cleared");

    a_trunc_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tag.valid && o_tag.truncated) |-> o_tag.tag_end)
        else $error("truncated word does not end its tag");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_move) |-> !i_adts.ready)
        else $error("queue full but input ready");

endmodule

`default_nettype wire

FILE: sim/adts_to_flv_audio_tagger_checker.sv
`timescale 1ns / 1ps

module adts_to_flv_audio_tagger_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    aflv_adts_if i_adts,
    aflv_tag_if  i_tag,
    output int   o_fail_count,
    output int   o_pending_count
);
    import aflv_pkg::*;

    typedef enum logic [1:0] {
        FM_IDLE,
        FM_SEQ_HDR,
        FM_RAW,
        FM_SKIP
    } frame_mode_e;

    localparam logic KIND_SEQ = 1'b0;
    localparam logic KIND_RAW = 1'b1;

    localparam logic [LEN_W-1:0] ASC_PROFILE_POS = 13'd2;
    localparam logic [LEN_W-1:0] ASC_CHAN_POS    = 13'd3;
    localparam logic [LEN_W-1:0] PAYLOAD_POS     = ADTS_HDR_LEN;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              kind;
        logic              trunc;
    } tag_word_t;

    tag_word_t tag_words_due[$];

    logic              header_sent;
    logic [LEN_W-1:0]  frame_pos;
    logic [LEN_W-1:0]  frame_len;
    logic [TS_W-1:0]   frame_stamp;
    logic [DATA_W-1:0] asc_src_byte;
    frame_mode_e       mode;
    int                mismatch_total;

    task automatic queue_word(input logic [DATA_W-1:0] d, input logic last_flag,
                              input logic kind_flag, input logic trunc_flag);
        tag_word_t w;
        w.data  = d;
        w.last  = last_flag;
        w.kind  = kind_flag;
        w.trunc = trunc_flag;
        tag_words_due.push_back(w);
    endtask

    task automatic queue_tag_header(input logic [23:0] size, input logic kind_flag);
        queue_word(FLV_TAG_AUDIO, 1'b0, kind_flag, 1'b0);
        queue_word(size[23:16], 1'b0, kind_flag, 1'b0);
        queue_word(size[15:8], 1'b0, kind_flag, 1'b0);
        queue_word(size[7:0], 1'b0, kind_flag, 1'b0);
        queue_word(frame_stamp[23:16], 1'b0, kind_flag, 1'b0);
        queue_word(frame_stamp[15:8], 1'b0, kind_flag, 1'b0);
        queue_word(frame_stamp[7:0], 1'b0, kind_flag, 1'b0);
        queue_word(frame_stamp[31:24], 1'b0, kind_flag, 1'b0);
        // stream id
        repeat (3) queue_word(8'h00, 1'b0, kind_flag, 1'b0);
    endtask

    task automatic predict_frame_byte(input logic [DATA_W-1:0] data,
                                      input logic [LEN_W-1:0] flen,
                                      input logic [TS_W-1:0] ts, input logic fend);
        logic [LEN_W-1:0] pos;
        logic [2:0]       profile;
        logic [3:0]       rate_idx;
        logic [2:0]       chan_cfg;
        logic             at_len;
        if (mode == FM_IDLE) begin
            pos         = '0;
            frame_len   = flen;
            frame_stamp = ts;
            if (flen <= ADTS_HDR_LEN) begin
                mode = FM_SKIP;
            end else if (!header_sent) begin
                mode = FM_SEQ_HDR;
            end else begin
                mode = FM_RAW;
                queue_tag_header(24'(flen - RAW_SIZE_ADJ), KIND_RAW);
                queue_word(AAC_SOUND_BYTE, 1'b0, KIND_RAW, 1'b0);
                queue_word(AAC_PKT_RAW, 1'b0, KIND_RAW, 1'b0);
            end
        end else begin
            pos = frame_pos;
        end

        case (mode)
            FM_SEQ_HDR: begin
                if (pos == ASC_PROFILE_POS) begin
                    asc_src_byte = data;
                end else if (pos == ASC_CHAN_POS) begin
                    profile  = 3'(asc_src_byte[7:6]) + 3'd1;
                    rate_idx = asc_src_byte[5:2];
                    chan_cfg = {asc_src_byte[0], data[7:6]};
                    queue_tag_header(24'(SEQ_TAG_SIZE), KIND_SEQ);
                    queue_word(AAC_SOUND_BYTE, 1'b0, KIND_SEQ, 1'b0);
                    queue_word(AAC_PKT_SEQ, 1'b0, KIND_SEQ, 1'b0);
                    queue_word({2'b00, profile, rate_idx[3:1]}, 1'b0, KIND_SEQ, 1'b0);
                    queue_word({rate_idx[0], 1'b0, chan_cfg, 3'b000}, 1'b1, KIND_SEQ, 1'b0);
                    header_sent = 1'b1;
                end
            end
            FM_RAW: begin
                if (pos >= PAYLOAD_POS && pos < frame_len) begin
                    at_len = (pos == frame_len - 13'd1);
                    queue_word(data, at_len | fend, KIND_RAW, fend & !at_len);
                end else if (fend && pos < PAYLOAD_POS) begin
                    // frame died inside the ADTS header: close the tag with a filler word
                    queue_word(8'h00, 1'b1, KIND_RAW, 1'b1);
                end
            end
            default: ;
        endcase

        if (fend) begin
            mode      = FM_IDLE;
            frame_pos = '0;
        end else begin
            frame_pos = (pos < POS_MAX) ? pos + 13'd1 : POS_MAX;
        end
    endtask

    always @(posedge i_clk) begin
        tag_word_t got;
        tag_word_t due;
        if (!i_rst_n) begin
            header_sent    = 1'b0;
            frame_pos      = '0;
            frame_len      = '0;
            frame_stamp    = '0;
            asc_src_byte   = '0;
            mode           = FM_IDLE;
            mismatch_total = 0;
            tag_words_due.delete();
        end else begin
            if (i_adts.valid && i_adts.ready) begin
                predict_frame_byte(i_adts.adts_data, i_adts.frame_length,
                                   i_adts.time_stamp, i_adts.frame_end);
            end
            if (i_tag.valid && i_tag.ready) begin
                got.data  = i_tag.tag_data;
                got.last  = i_tag.tag_end;
                got.kind  = i_tag.tag_kind;
                got.trunc = i_tag.truncated;
                if (tag_words_due.size() == 0) begin
                    mismatch_total++;
                    $display("t=%0t: unexpected tag word, expected none, got data=%h end=%b",
                             $time, got.data, got.last, " kind=%b truncated=%b",
                             got.kind, got.trunc);
                end else begin
                    due = tag_words_due.pop_front();
                    if (got !== due) begin
                        mismatch_total++;
                        $display("t=%0t: tag word mismatch, expected data=%h end=%b kind=%b",
                                 $time, due.data, due.last, due.kind,
                                 " truncated=%b, got data=%h end=%b kind=%b truncated=%b",
                                 due.trunc, got.data, got.last, got.kind, got.trunc);
                    end
                end
            end
        end
        o_fail_count    <= mismatch_total;
        o_pending_count <= tag_words_due.size();
    end

endmodule

FILE: sim/adts_to_flv_audio_tagger_tb.sv
`timescale 1ns / 1ps

module adts_to_flv_audio_tagger_tb;
    import aflv_pkg::*;

    localparam int RANDOM_WORDS   = 270;
    localparam int QUIET_FROM     = 210;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic quiet_phase;
    logic hold_go;
    logic hold_done;
    int   fail_total;
    int   words_pending;
    int   idle_cycles;

    aflv_adts_if adts_ch();
    aflv_tag_if  tag_ch();

    adts_to_flv_audio_tagger u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adts  (adts_ch),
        .o_tag   (tag_ch)
    );

    adts_to_flv_audio_tagger_checker u_tag_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adts          (adts_ch),
        .i_tag           (tag_ch),
        .o_fail_count    (fail_total),
        .o_pending_count (words_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_word(input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] fl,
                             input logic [TS_W-1:0] ts, input logic fe);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            adts_ch.valid     <= 1'b0;
            adts_ch.adts_data <= DATA_W'($urandom);
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        adts_ch.valid        <= 1'b1;
        adts_ch.adts_data    <= d;
        adts_ch.frame_length <= fl;
        adts_ch.time_stamp   <= ts;
        adts_ch.frame_end    <= fe;
        do @(posedge i_clk); while (!adts_ch.ready);
    endtask

    // jitter: scramble length and stamp after the first word, where they must be ignored
    task automatic send_frame(input logic [LEN_W-1:0] flen, input logic [TS_W-1:0] ts,
                              input int count, input logic jitter);
        logic [LEN_W-1:0] fl_w;
        logic [TS_W-1:0]  ts_w;
        for (int i = 0; i < count; i++) begin
            fl_w = (jitter && i > 0) ? LEN_W'($urandom) : flen;
            ts_w = (jitter && i > 0) ? $urandom : ts;
            send_word(DATA_W'($urandom), fl_w, ts_w, i == count - 1);
        end
    endtask

    function automatic logic [TS_W-1:0] pick_stamp();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int               counted;
        int               pick;
        int               count;
        logic [LEN_W-1:0] flen;
        i_rst_n              = 1'b0;
        adts_ch.valid        = 1'b0;
        adts_ch.adts_data    = '0;
        adts_ch.frame_length = '0;
        adts_ch.time_stamp   = '0;
        adts_ch.frame_end    = 1'b0;
        quiet_phase          = 1'b0;
        hold_go              = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short frames are skipped whole
        send_frame(13'd0, 32'h0000_0000, 1, 1'b0);
        send_frame(13'd7, 32'hFFFF_FFFF, 7, 1'b0);
        send_frame(13'd5, $urandom, 10, 1'b0);
        // header frames that end before the config byte leave the header pending
        send_frame(13'd20, $urandom, 2, 1'b0);
        send_frame(13'd20, $urandom, 3, 1'b0);
        // header goes out on byte 3, then the frame ends early
        send_frame(13'd40, pick_stamp(), 6, 1'b0);
        send_frame(13'd8, 32'h0000_0000, 8, 1'b0);
        // longest frame length, cut short
        send_frame(13'h1FFF, 32'hFFFF_FFFF, 12, 1'b0);
        send_frame(13'd20, $urandom, 1, 1'b0);
        send_frame(13'd20, $urandom, 7, 1'b0);
        send_frame(13'd20, $urandom, 8, 1'b0);
        send_frame(13'd9, $urandom, 12, 1'b0);
        send_frame(13'd30, $urandom, 30, 1'b1);

        hold_go <= 1'b1;
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            if (counted >= QUIET_FROM) quiet_phase <= 1'b1;
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                flen  = LEN_W'($urandom_range(100, 8191));
                count = $urandom_range(8, 60);
            end else if (pick < 26) begin
                flen  = LEN_W'($urandom_range(8, 40));
                count = flen;
            end else if (pick < 31) begin
                flen  = LEN_W'($urandom_range(8, 40));
                count = $urandom_range(1, flen - 1);
            end else if (pick < 35) begin
                flen  = LEN_W'($urandom_range(8, 24));
                count = flen + $urandom_range(1, 6);
            end else begin
                flen  = LEN_W'($urandom_range(0, 7));
                count = $urandom_range(1, 10);
            end
            send_frame(flen, pick_stamp(), count, pick == 39);
            counted += count;
        end
        adts_ch.valid <= 1'b0;

        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_total == 0 && words_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        tag_ch.ready = 1'b0;
        hold_done    = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_go && !hold_done) begin
                // hold off long enough for the block to fill and stall its input
                tag_ch.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                tag_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                tag_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (adts_ch.valid && adts_ch.ready) || (tag_ch.valid && tag_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: sim.f
hw/rtl/aflv_pkg.sv
hw/rtl/aflv_adts_if.sv
hw/rtl/aflv_tag_if.sv
hw/rtl/adts_to_flv_audio_tagger.sv
sim/adts_to_flv_audio_tagger_checker.sv
sim/adts_to_flv_audio_tagger_tb.sv
